### hw/rtl/rce_pkg.sv
// Shared types, character constants and helper functions for the RTF
// character escape encoder and its checker. No dependencies.
package rce_pkg;

	localparam int MAP_COUNT = 19;
	localparam int MAP_IDX_W = $clog2(MAP_COUNT);
	localparam int RUN_MAX   = 11;
	localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);
	localparam int CODE_W    = 16;
	localparam int CHAR_W    = 7;
	localparam int DIGITS    = 5;

	localparam logic [CHAR_W-1:0] CH_BSL  = 7'h5C;
	localparam logic [CHAR_W-1:0] CH_LBR  = 7'h7B;
	localparam logic [CHAR_W-1:0] CH_RBR  = 7'h7D;
	localparam logic [CHAR_W-1:0] CH_U    = 7'h75;
	localparam logic [CHAR_W-1:0] CH_SP   = 7'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;

	localparam logic [CODE_W-1:0] CODE_DEL = 16'd127;
	localparam logic [CODE_W-1:0] CODE_SP  = 16'd32;

	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_ESC,
		KIND_MAP,
		KIND_UNI
	} kind_t;

	typedef struct packed {
		logic                 hit;
		logic [MAP_IDX_W-1:0] idx;
	} map_hit_t;

	typedef struct packed {
		logic [8*RUN_MAX-1:0] txt;   // left aligned, first byte in the top octet
		logic [RUN_LEN_W-1:0] len;
	} map_text_t;

	typedef struct packed {
		logic [CODE_W-1:0] q;
		logic [3:0]        r;
	} div10_t;

	localparam logic [CODE_W-1:0] MAP_CODE [MAP_COUNT] = '{
		16'h0009, 16'h00A0, 16'h00AD, 16'h00B7, 16'h2011,
		16'h2002, 16'h2003, 16'h2004, 16'h200C, 16'h200D,
		16'h200E, 16'h200F, 16'h2013, 16'h2014, 16'h2018,
		16'h2019, 16'h201C, 16'h201D, 16'h2022
	};

	// codes in the table are distinct, so at most one compare fires
	function automatic map_hit_t map_lookup(input logic [CODE_W-1:0] c);
		map_hit_t r;
		r = '0;
		for (int i = 0; i < MAP_COUNT; i++) begin
			if (c == MAP_CODE[i]) begin
				r.hit = 1'b1;
				r.idx = MAP_IDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic map_text_t map_text(input logic [MAP_IDX_W-1:0] idx);
		map_text_t r;
		logic [8*RUN_MAX-1:0] t;
		logic [RUN_LEN_W-1:0] n;
		unique case (idx)
			5'd0:  begin t = 88'("\\tab ");       n = 4'd5;  end
			5'd1:  begin t = 88'("\\~");          n = 4'd2;  end
			5'd2:  begin t = 88'("\\-");          n = 4'd2;  end
			5'd3:  begin t = 88'("\\|");          n = 4'd2;  end
			5'd4:  begin t = 88'("\\_");          n = 4'd2;  end
			5'd5:  begin t = 88'("\\enspace ");   n = 4'd9;  end
			5'd6:  begin t = 88'("\\emspace ");   n = 4'd9;  end
			5'd7:  begin t = 88'("\\qmspace ");   n = 4'd9;  end
			5'd8:  begin t = 88'("\\zwnj ");      n = 4'd6;  end
			5'd9:  begin t = 88'("\\zwj ");       n = 4'd5;  end
			5'd10: begin t = 88'("\\ltrmark ");   n = 4'd9;  end
			5'd11: begin t = 88'("\\rtrmark ");   n = 4'd9;  end
			5'd12: begin t = 88'("\\endash ");    n = 4'd8;  end
			5'd13: begin t = 88'("\\emdash ");    n = 4'd8;  end
			5'd14: begin t = 88'("\\lquote ");    n = 4'd8;  end
			5'd15: begin t = 88'("\\rquote ");    n = 4'd8;  end
			5'd16: begin t = 88'("\\ldblquote "); n = 4'd11; end
			5'd17: begin t = 88'("\\rdblquote "); n = 4'd11; end
			5'd18: begin t = 88'("\\bullet ");    n = 4'd8;  end
			default: begin t = '0;                n = 4'd1;  end
		endcase
		r.txt = t << (8 * (RUN_MAX - int'(n)));
		r.len = n;
		return r;
	endfunction

	// exact quotient and remainder by ten for any 16-bit value
	function automatic div10_t div10(input logic [CODE_W-1:0] v);
		div10_t r;
		logic [32:0] p;
		logic [CODE_W-1:0] t;
		p   = 33'(v) * 33'd52429;
		r.q = CODE_W'(p[32:19]);
		t   = v - ((r.q << 3) + (r.q << 1));
		r.r = t[3:0];
		return r;
	endfunction

endpackage

### hw/rtl/rtf_char_escape_encoder.sv
// RTF character escape encoder: top level, pipeline and byte serialiser.
// Depends on rce_pkg.
//
// Usage:
//   Input channel  (in_valid, in_stall, code_unit): one UTF-16 code unit per word.
//   Output channel (out_valid, out_stall, out_char, last_char): one ASCII byte
//   per word; last_char marks the final byte of the run for a code unit.
//   A word moves when valid is high and stall is low at a rising edge.
//   An accepted unit passes stages 1 to 4, then the serialiser. Throughput: one
//   code unit per cycle while each yields a single byte and out_stall is low; a
//   unit whose run has N bytes (up to 11 for the double quote words) holds the
//   serialiser until all N have gone out. Of the four stages in front, stage 1
//   registers the input, stage 2 classifies and divides by ten, stages 3 and 4
//   divide by ten once each; they keep filling while the serialiser is busy.
//   When out_stall is high the current byte holds and the pipe backs up stage
//   by stage; in_stall rises only once every stage is full. Nothing is lost.
//   Reset (arst_n low) empties every stage at once; no clearing pass.
module rtf_char_escape_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rce_pkg::CODE_W-1:0] code_unit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rce_pkg::CHAR_W-1:0] out_char,
	output logic                       last_char
);

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic                          en_s1, en_s2, en_s3, en_s4, ser_rdy;
	logic [rce_pkg::CODE_W-1:0]    code_s1;

	rce_pkg::kind_t                kind_s2, kind_s3, kind_s4;
	logic [rce_pkg::MAP_IDX_W-1:0] midx_s2, midx_s3, midx_s4;
	logic [2:0]                    nd_s2, nd_s3, nd_s4;
	logic [rce_pkg::CHAR_W-1:0]    ch_s2, ch_s3, ch_s4;
	logic [12:0]                   quot_s2;
	logic [9:0]                    quot_s3;
	logic [6:0]                    quot_s4;
	logic [3:0]                    dig_s2;
	logic [1:0][3:0]               dig_s3;
	logic [2:0][3:0]               dig_s4;

	logic [rce_pkg::CHAR_W-1:0]    buf_q [rce_pkg::RUN_MAX];
	logic [rce_pkg::RUN_LEN_W-1:0] rem_q;
	logic                          out_acc;

	// ---- flow control
	assign out_acc  = out_valid && !out_stall;
	assign ser_rdy  = (rem_q == '0) || ((rem_q == rce_pkg::RUN_LEN_W'(1)) && !out_stall);
	assign en_s4    = !v_s4 || ser_rdy;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// ---- stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			code_s1 <= code_unit;
		end
	end

	// ---- stage 2: classify, first digit
	rce_pkg::map_hit_t mh_c1;
	rce_pkg::kind_t    kind_c1;
	logic [2:0]        nd_c1;
	rce_pkg::div10_t   dv_c1;

	always_comb begin
		mh_c1 = rce_pkg::map_lookup(code_s1);
		dv_c1 = rce_pkg::div10(code_s1);
		priority if (code_s1 == 16'(rce_pkg::CH_BSL) || code_s1 == 16'(rce_pkg::CH_LBR)
				|| code_s1 == 16'(rce_pkg::CH_RBR)) begin
			kind_c1 = rce_pkg::KIND_ESC;
		end else if (code_s1 >= rce_pkg::CODE_SP && code_s1 < rce_pkg::CODE_DEL) begin
			kind_c1 = rce_pkg::KIND_RAW;
		end else if (mh_c1.hit) begin
			kind_c1 = rce_pkg::KIND_MAP;
		end else if (code_s1 >= rce_pkg::CODE_DEL) begin
			kind_c1 = rce_pkg::KIND_UNI;
		end else begin
			kind_c1 = rce_pkg::KIND_RAW;
		end
		priority if (code_s1 >= 16'd10000) nd_c1 = 3'd5;
		else if (code_s1 >= 16'd1000)      nd_c1 = 3'd4;
		else if (code_s1 >= 16'd100)       nd_c1 = 3'd3;
		else if (code_s1 >= 16'd10)        nd_c1 = 3'd2;
		else                               nd_c1 = 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			kind_s2 <= kind_c1;
			midx_s2 <= mh_c1.idx;
			nd_s2   <= nd_c1;
			ch_s2   <= code_s1[rce_pkg::CHAR_W-1:0];
			quot_s2 <= dv_c1.q[12:0];
			dig_s2  <= dv_c1.r;
		end
	end

	// ---- stage 3: second digit
	rce_pkg::div10_t dv_c2;
	assign dv_c2 = rce_pkg::div10(16'(quot_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			kind_s3 <= kind_s2;
			midx_s3 <= midx_s2;
			nd_s3   <= nd_s2;
			ch_s3   <= ch_s2;
			quot_s3 <= dv_c2.q[9:0];
			dig_s3  <= {dv_c2.r, dig_s2};
		end
	end

	// ---- stage 4: third digit
	rce_pkg::div10_t dv_c3;
	assign dv_c3 = rce_pkg::div10(16'(quot_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			kind_s4 <= kind_s3;
			midx_s4 <= midx_s3;
			nd_s4   <= nd_s3;
			ch_s4   <= ch_s3;
			quot_s4 <= dv_c3.q[6:0];
			dig_s4  <= {dv_c3.r, dig_s3};
		end
	end

	// ---- run assembly: last two digits, then the byte string
	rce_pkg::div10_t                   dv_c4;
	rce_pkg::map_text_t                mt_c4;
	logic [rce_pkg::DIGITS-1:0][3:0]   dig_c4;
	logic [rce_pkg::CHAR_W-1:0]        bld_c4 [rce_pkg::RUN_MAX];
	logic [rce_pkg::RUN_LEN_W-1:0]     len_c4;
	logic [2:0]                        dsel_c4;

	always_comb begin
		dv_c4   = rce_pkg::div10(16'(quot_s4));
		mt_c4   = rce_pkg::map_text(midx_s4);
		dig_c4  = {dv_c4.q[3:0], dv_c4.r, dig_s4};
		dsel_c4 = '0;
		for (int k = 0; k < rce_pkg::RUN_MAX; k++) begin
			bld_c4[k] = '0;
		end
		unique case (kind_s4)
			rce_pkg::KIND_RAW: begin
				bld_c4[0] = ch_s4;
				len_c4    = rce_pkg::RUN_LEN_W'(1);
			end
			rce_pkg::KIND_ESC: begin
				bld_c4[0] = rce_pkg::CH_BSL;
				bld_c4[1] = ch_s4;
				len_c4    = rce_pkg::RUN_LEN_W'(2);
			end
			rce_pkg::KIND_MAP: begin
				for (int k = 0; k < rce_pkg::RUN_MAX; k++) begin
					bld_c4[k] = mt_c4.txt[8*(rce_pkg::RUN_MAX-1-k) +: rce_pkg::CHAR_W];
				end
				len_c4 = mt_c4.len;
			end
			rce_pkg::KIND_UNI: begin
				bld_c4[0] = rce_pkg::CH_BSL;
				bld_c4[1] = rce_pkg::CH_U;
				// most significant digit first, then the closing space
				for (int p = 2; p < 2 + rce_pkg::DIGITS + 1; p++) begin
					if (p - 2 < int'(nd_s4)) begin
						dsel_c4   = 3'(int'(nd_s4) + 1 - p);
						bld_c4[p] = rce_pkg::CH_ZERO + rce_pkg::CHAR_W'(dig_c4[dsel_c4]);
					end else if (p - 2 == int'(nd_s4)) begin
						bld_c4[p] = rce_pkg::CH_SP;
					end
				end
				len_c4 = rce_pkg::RUN_LEN_W'(nd_s4) + rce_pkg::RUN_LEN_W'(3);
			end
			default: begin
				len_c4 = rce_pkg::RUN_LEN_W'(1);
			end
		endcase
	end

	// ---- serialiser: shift register, byte 0 is on the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ser_rdy && v_s4) begin
			rem_q <= len_c4;
		end else if (out_acc) begin
			rem_q <= rem_q - rce_pkg::RUN_LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_rdy && v_s4) begin
			buf_q <= bld_c4;
		end else if (out_acc) begin
			for (int k = 0; k < rce_pkg::RUN_MAX - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

	assign out_valid = (rem_q != '0);
	assign out_char  = buf_q[0];
	assign last_char = (rem_q == rce_pkg::RUN_LEN_W'(1));

endmodule

### hw/rtl/rce_checker.sv
// Port-level checker for the RTF character escape encoder, bound to the
// top level below. Depends on the top level's ports only.
module rce_assert (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [15:0]                code_unit,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [6:0]                 out_char,
	input logic                       last_char
);

	// code units accepted whose last byte has not yet gone out
	logic [3:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(in_valid && !in_stall)
				- 4'(out_valid && !out_stall && last_char);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char))
		else $error("stalled output word changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 4'd0)
		else $error("output word with no code unit outstanding");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 4'd0 |-> !in_stall)
		else $error("input stalled with empty pipe");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_char |=> out_valid)
		else $error("gap inside a byte run");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'd5)
		else $error("more code units outstanding than the pipe holds");

endmodule

bind rtf_char_escape_encoder rce_assert u_rce_assert (.*);

### sim/rce_checker.sv
`timescale 1ns / 1ps
// Checker for the RTF character escape encoder: watches both channels, predicts
// the byte run for every accepted code unit and compares each output word.
// Depends on rce_pkg for the port widths and character constants.
module rce_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [rce_pkg::CODE_W-1:0] code_unit,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [rce_pkg::CHAR_W-1:0] out_char,
	input  logic                       last_char,
	output int                         fail_count,
	output int                         pending,
	output int                         unit_count,
	output int                         byte_count
);

	typedef struct packed {
		logic [rce_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} rtf_byte_t;

	rtf_byte_t expected_bytes [$];
	int        errors = 0;
	int        units  = 0;
	int        bytes  = 0;

	// fixed control words and symbols; empty string when the code is not mapped
	function automatic string control_word(input logic [rce_pkg::CODE_W-1:0] c);
		case (c)
			16'h0009: return "\\tab ";
			16'h00A0: return "\\~";
			16'h00AD: return "\\-";
			16'h00B7: return "\\|";
			16'h2011: return "\\_";
			16'h2002: return "\\enspace ";
			16'h2003: return "\\emspace ";
			16'h2004: return "\\qmspace ";
			16'h200C: return "\\zwnj ";
			16'h200D: return "\\zwj ";
			16'h200E: return "\\ltrmark ";
			16'h200F: return "\\rtrmark ";
			16'h2013: return "\\endash ";
			16'h2014: return "\\emdash ";
			16'h2018: return "\\lquote ";
			16'h2019: return "\\rquote ";
			16'h201C: return "\\ldblquote ";
			16'h201D: return "\\rdblquote ";
			16'h2022: return "\\bullet ";
			default:  return "";
		endcase
	endfunction

	task automatic predict_escape_run(input logic [rce_pkg::CODE_W-1:0] c);
		string                      text;
		logic [rce_pkg::CHAR_W-1:0] run [16];
		int                         n;
		byte                        b;
		rtf_byte_t                  w;
		text = control_word(c);
		n    = 0;
		if (c == 16'(rce_pkg::CH_BSL) || c == 16'(rce_pkg::CH_LBR)
				|| c == 16'(rce_pkg::CH_RBR)) begin
			run[0] = rce_pkg::CH_BSL;
			run[1] = c[rce_pkg::CHAR_W-1:0];
			n      = 2;
		end else if (c >= rce_pkg::CODE_SP && c < rce_pkg::CODE_DEL) begin
			run[0] = c[rce_pkg::CHAR_W-1:0];
			n      = 1;
		end else if (text.len() == 0 && c < rce_pkg::CODE_DEL) begin
			// control codes other than tab go out as they are
			run[0] = c[rce_pkg::CHAR_W-1:0];
			n      = 1;
		end else begin
			if (text.len() == 0)
				text = $sformatf("\\u%0d ", c);
			for (int i = 0; i < text.len(); i++) begin
				b      = text[i];
				run[i] = b[rce_pkg::CHAR_W-1:0];
			end
			n = text.len();
		end
		for (int i = 0; i < n; i++) begin
			w.ch   = run[i];
			w.last = (i == n - 1);
			expected_bytes.push_back(w);
		end
	endtask

	always @(posedge clk) begin
		rtf_byte_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_escape_run(code_unit);
				units++;
			end
			if (out_valid && !out_stall) begin
				bytes++;
				if (expected_bytes.size() == 0) begin
					$error("output word with nothing expected: out_char=%0h last_char=%0b",
						out_char, last_char);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected %0h, got %0h", want.ch, out_char);
						errors++;
					end
					if (last_char !== want.last) begin
						$error("last_char: expected %0b, got %0b", want.last, last_char);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending    <= expected_bytes.size();
		unit_count <= units;
		byte_count <= bytes;
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the RTF character escape encoder: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Uses rce_pkg, rce_checker and the encoder.
module tb_top;

	localparam int N_RANDOM   = 354;
	localparam int IDLE_LIMIT = 4000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BURSTY
	} stall_mode_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic [rce_pkg::CODE_W-1:0] code_unit = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [rce_pkg::CHAR_W-1:0] out_char;
	logic                       last_char;

	int fail_count;
	int pending;
	int unit_count;
	int byte_count;

	int          burst_left = 0;
	int          idle_cycles = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          run_left = 0;

	rtf_char_escape_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last_char (last_char)
	);

	rce_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last_char  (last_char),
		.fail_count (fail_count),
		.pending    (pending),
		.unit_count (unit_count),
		.byte_count (byte_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [rce_pkg::CODE_W-1:0] typo_code(input int k);
		case (k)
			0:  return 16'h0009;
			1:  return 16'h00A0;
			2:  return 16'h00AD;
			3:  return 16'h00B7;
			4:  return 16'h2011;
			5:  return 16'h2002;
			6:  return 16'h2003;
			7:  return 16'h2004;
			8:  return 16'h200C;
			9:  return 16'h200D;
			10: return 16'h200E;
			11: return 16'h200F;
			12: return 16'h2013;
			13: return 16'h2014;
			14: return 16'h2018;
			15: return 16'h2019;
			16: return 16'h201C;
			17: return 16'h201D;
			default: return 16'h2022;
		endcase
	endfunction

	// range ends, the escaped characters, digit-count boundaries and an unmapped neighbour of the mapped codes
	function automatic logic [rce_pkg::CODE_W-1:0] edge_code(input int k);
		case (k)
			0:  return 16'h0000;
			1:  return 16'h007E;
			2:  return 16'h007F;
			3:  return 16'hFFFF;
			4:  return {9'd0, rce_pkg::CH_BSL};
			5:  return {9'd0, rce_pkg::CH_LBR};
			6:  return {9'd0, rce_pkg::CH_RBR};
			7:  return 16'd999;
			8:  return 16'd1000;
			9:  return 16'd9999;
			10: return 16'd10000;
			11: return 16'h2010;
			default: return 16'h001F;
		endcase
	endfunction

	function automatic logic [rce_pkg::CODE_W-1:0] pick_code();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 25)
			return 16'($urandom_range(32, 126));
		else if (sel < 35)
			return edge_code($urandom_range(4, 6));
		else if (sel < 45)
			return 16'($urandom_range(0, 31));
		else if (sel < 65)
			return typo_code($urandom_range(0, 18));
		else if (sel < 75)
			return edge_code($urandom_range(0, 12)) + 16'($urandom_range(0, 2));
		else
			return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_unit(input logic [rce_pkg::CODE_W-1:0] c);
		in_valid  <= 1'b1;
		code_unit <= c;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
				: $urandom_range(10, 40);
		end
	endtask

	// hold off the sender until every predicted byte has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver stall pattern, switching mode every so often
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left  <= $urandom_range(20, 200);
		end else
			mode_left <= mode_left - 1;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left  <= $urandom_range(1, 12);
				end else
					run_left <= run_left - 1;
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("rtf_char_escape_encoder test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 19; k++)
			send_unit(typo_code(k));
		for (int k = 0; k < 7; k++)
			send_unit(edge_code(k));

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 2)
				drain();
			send_unit(pick_code());
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Run covered %0d code units, giving %0d checked output bytes,",
			unit_count, byte_count);
		$display("with every control word, escape, control code and decimal length exercised.");
		if (fail_count == 0 && pending == 0)
			$display("rtf_char_escape_encoder test passed");
		else begin
			if (pending != 0)
				$error("%0d expected bytes never arrived", pending);
			$display("rtf_char_escape_encoder test failed");
		end
		$finish;
	end

endmodule
